// File: hdl/srtt_pkg.sv
// ----------------------------------------------------------------------------
// srtt_pkg - shared constants for the stepper ramp timer table
// Field widths, register codes, reset values and ramp thresholds.
// ----------------------------------------------------------------------------
package srtt_pkg;

    // Defaults of the top-level parameters
    localparam int unsigned DEF_CLOCK_HZ    = 72000000;
    localparam int unsigned DEF_MAX_STAGES  = 30;
    localparam int unsigned DEF_TIMER_LIMIT = 65535;

    // Field widths
    localparam int IV_W       = 16;
    localparam int RATE_W     = 24;
    localparam int MSR_W      = 10;
    localparam int DIST_W     = 32;
    localparam int STAGE_W    = 5;
    localparam int PRE_W      = 16;
    localparam int PER_W      = 16;
    localparam int CMP_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SID_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO    = 2'd2;

    // Register reset values
    localparam logic [IV_W-1:0]   RST_SID_INTERVAL = 16'd6201;
    localparam logic [RATE_W-1:0] RST_STEP_RATE    = 24'd279809;
    localparam logic [MSR_W-1:0]  RST_MAX_RATIO    = 10'd250;

    // Speed ratio limits and the stage counts they select
    localparam logic [IV_W-1:0] RATIO_LIM_3  = 16'd5;
    localparam logic [IV_W-1:0] RATIO_LIM_4  = 16'd10;
    localparam logic [IV_W-1:0] RATIO_LIM_8  = 16'd20;
    localparam logic [IV_W-1:0] RATIO_LIM_15 = 16'd30;
    localparam logic [IV_W-1:0] RATIO_LIM_30 = 16'd150;

    localparam logic [STAGE_W-1:0] STAGES_2  = 5'd2;
    localparam logic [STAGE_W-1:0] STAGES_3  = 5'd3;
    localparam logic [STAGE_W-1:0] STAGES_4  = 5'd4;
    localparam logic [STAGE_W-1:0] STAGES_8  = 5'd8;
    localparam logic [STAGE_W-1:0] STAGES_15 = 5'd15;
    localparam logic [STAGE_W-1:0] STAGES_30 = 5'd30;

    // Timer saturation points
    localparam logic [PRE_W-1:0] PRESCALE_SAT = 16'hFFFF;
    localparam logic [PRE_W:0]   DIVISOR_SAT  = 17'h10000;
    localparam logic [PER_W-1:0] PERIOD_MAX   = 16'hFFFF;

endpackage

// File: hdl/srtt_div.sv
// ----------------------------------------------------------------------------
// srtt_div - bit-serial restoring divider
// One quotient bit per cycle, MSB first; done pulses after DW steps.
// ----------------------------------------------------------------------------
module srtt_div #(
    parameter int DW = 50,
    parameter int DV = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DV-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [DV-1:0] r_rem;
    logic [DV-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DV:0]   n_shift;
    logic [DV:0]   n_diff;
    logic          n_fits;

    // Bring down the next dividend bit and try the subtraction
    assign n_shift = {r_rem, r_q[DW-1]};
    assign n_diff  = n_shift - {1'b0, r_dvs};
    assign n_fits  = (n_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], n_fits};
                r_rem <= n_fits ? n_diff[DV-1:0] : n_shift[DV-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: hdl/stepper_ramp_timer_table.sv
// ----------------------------------------------------------------------------
// stepper_ramp_timer_table - stepper acceleration ramp generator
// Turns one speed request into one timer setting per ramp stage.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------------
//  in        sink       i_in_valid / o_in_ready    target_interval, goto_mode,
//                                                  goto_distance
//  out       source     o_out_valid / i_out_ready  ramp_stage, prescaler, period,
//                                                  compare, stage_steps,
//                                                  decelerate, hold_speed, last
//  cfg       sink       i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
//  One request at a time. All divisions share one bit-serial divider of dividend
//  width DW (DW = clog2(CLOCK_HZ+1) + clog2(MAX_STAGES+1) + 18, 50 at the
//  defaults). Setup costs two divisions plus a shift-add multiply over the
//  16+clog2(MAX_STAGES+1) bits of interval * stages; each stage costs three
//  divisions.
//  A finished stage waits in the output register; the next stage is computed
//  meanwhile, and the next request is taken as soon as the last stage is loaded.
//  Reset is synchronous and active low; it restores the configuration registers.
//  The configuration port is always ready.
//
module stepper_ramp_timer_table #(
    parameter int unsigned CLOCK_HZ    = srtt_pkg::DEF_CLOCK_HZ,
    parameter int unsigned MAX_STAGES  = srtt_pkg::DEF_MAX_STAGES,
    parameter int unsigned TIMER_LIMIT = srtt_pkg::DEF_TIMER_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration requests
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srtt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srtt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Speed requests
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [srtt_pkg::IV_W-1:0]       i_target_interval,
    input  logic                            i_goto_mode,
    input  logic [srtt_pkg::DIST_W-1:0]     i_goto_distance,
    // Ramp stages
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [srtt_pkg::STAGE_W-1:0]    o_ramp_stage,
    output logic [srtt_pkg::PRE_W-1:0]      o_prescaler,
    output logic [srtt_pkg::PER_W-1:0]      o_period,
    output logic [srtt_pkg::CMP_W-1:0]      o_compare,
    output logic [srtt_pkg::DIST_W-1:0]     o_stage_steps,
    output logic                            o_decelerate,
    output logic                            o_hold_speed,
    output logic                            o_last
);

    import srtt_pkg::*;

    localparam int CLK_W = $clog2(CLOCK_HZ + 1);
    localparam int STG_W = $clog2(MAX_STAGES + 1);
    localparam int IVS_W = IV_W + STG_W;          // interval * stages
    localparam int NUM_W = CLK_W + IVS_W;         // CLOCK_HZ * interval * stages
    localparam int DW    = NUM_W + 2;             // divider dividend width
    localparam int DEN_W = RATE_W + STG_W;        // step_rate * stage
    localparam int DV    = DEN_W + 1;             // divider divisor width
    localparam int CUM_W = $clog2(MAX_STAGES * (MAX_STAGES + 1) / 2 + 1);
    localparam int MC_W  = $clog2(IVS_W + 1);
    localparam int J_W   = PRE_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MINIV,
        S_RATIO,
        S_MUL,
        S_STAGE,
        S_CNT,
        S_PRE,
        S_PER
    } t_state;

    // Stage count from the speed ratio, capped by MAX_STAGES
    function automatic logic [STG_W-1:0] f_stage_count(input logic [IV_W-1:0] ratio);
        logic [STAGE_W-1:0] s;
        if (ratio < RATIO_LIM_3) begin
            s = STAGES_2;
        end else if (ratio < RATIO_LIM_4) begin
            s = STAGES_3;
        end else if (ratio < RATIO_LIM_8) begin
            s = STAGES_4;
        end else if (ratio < RATIO_LIM_15) begin
            s = STAGES_8;
        end else if (ratio < RATIO_LIM_30) begin
            s = STAGES_15;
        end else begin
            s = STAGES_30;
        end
        if (int'(s) > int'(MAX_STAGES)) begin
            s = STAGE_W'(MAX_STAGES);
        end
        return STG_W'(s);
    endfunction

    t_state              r_state;

    // Configuration registers
    logic [IV_W-1:0]     r_sid;
    logic [RATE_W-1:0]   r_rate;
    logic [MSR_W-1:0]    r_msr;

    // Request and working registers
    logic [IV_W-1:0]     r_target;
    logic                r_goto;
    logic [DIST_W-1:0]   r_dist;
    logic [STG_W-1:0]    r_stages;
    logic [IVS_W-1:0]    r_ivs;
    logic [NUM_W-1:0]    r_num;
    logic [MC_W-1:0]     r_mcnt;
    logic [STG_W-1:0]    r_i;
    logic [DEN_W-1:0]    r_den;
    logic [CUM_W-1:0]    r_cum;       // steps of the stages before r_i
    logic [NUM_W-1:0]    r_count;
    logic [J_W-1:0]      r_j;
    logic [PER_W-1:0]    r_period;
    logic                r_emit;      // a stage result is ready to load

    // Divider request
    logic                r_div_start;
    logic [DW-1:0]       r_div_dvd;
    logic [DV-1:0]       r_div_dvs;
    logic                w_div_done;
    logic [DW-1:0]       w_q;

    // Output register
    logic                r_out_valid;
    logic [STAGE_W-1:0]  r_ramp_stage;
    logic [PRE_W-1:0]    r_prescaler;
    logic [PER_W-1:0]    r_period_out;
    logic [CMP_W-1:0]    r_compare;
    logic [DIST_W-1:0]   r_stage_steps;
    logic                r_decelerate;
    logic                r_hold_speed;
    logic                r_last;

    logic [MSR_W-1:0]    n_msr_eff;
    logic [RATE_W-1:0]   n_rate_eff;
    logic [IV_W-1:0]     n_iv_max;
    logic [IV_W-1:0]     n_iv;
    logic [NUM_W-1:0]    n_num;
    logic [J_W-1:0]      n_j;
    logic [PER_W-1:0]    n_period;
    logic [CUM_W-1:0]    n_cum;
    logic                n_dec;
    logic                n_final;
    logic                n_out_free;
    logic [DIST_W-1:0]   n_steps_fin;
    logic                n_div_start;
    logic                n_load;

    srtt_div #(
        .DW (DW),
        .DV (DV)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    // Zero ratio and zero rate count as one
    assign n_msr_eff  = (r_msr == '0) ? MSR_W'(1) : r_msr;
    assign n_rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;

    // Clamp to the fastest interval, never zero
    assign n_iv_max = (r_target < w_q[IV_W-1:0]) ? w_q[IV_W-1:0] : r_target;
    assign n_iv     = (n_iv_max == '0) ? IV_W'(1) : n_iv_max;

    // One multiplier bit per cycle, MSB first
    assign n_num = {r_num[NUM_W-2:0], 1'b0} + (r_ivs[IVS_W-1] ? NUM_W'(CLOCK_HZ) : '0);

    // Timer divisor j = count / limit + 1, saturated
    assign n_j = (w_q >= DW'(PRESCALE_SAT)) ? DIVISOR_SAT
                                             : (J_W'(w_q[PRE_W-1:0]) + J_W'(1));
    assign n_period = (w_q > DW'(PERIOD_MAX)) ? PERIOD_MAX : w_q[PER_W-1:0];

    // Goto cut: the move is too short for another stage each way
    assign n_cum       = r_cum + CUM_W'(r_i);
    assign n_dec       = r_goto && ((DIST_W + 1)'(r_dist) < (DIST_W + 1)'({n_cum, 1'b0}));
    assign n_final     = n_dec || (r_i == r_stages);
    assign n_steps_fin = r_dist - DIST_W'({r_cum, 1'b0});
    assign n_out_free  = !r_out_valid || i_out_ready;

    // Load a finished stage as soon as the output register frees up
    assign n_load = (r_state == S_PER) && r_emit && n_out_free;

    // Kick the divider on request, per stage, and after each chained result
    assign n_div_start = ((r_state == S_IDLE) && i_in_valid) || (r_state == S_STAGE) ||
                         (w_div_done && ((r_state == S_MINIV) || (r_state == S_CNT) ||
                                         (r_state == S_PRE)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sid       <= RST_SID_INTERVAL;
            r_rate      <= RST_STEP_RATE;
            r_msr       <= RST_MAX_RATIO;
            r_div_start <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= n_div_start;

            // Configuration writes; drop unknown indexes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SID_INTERVAL: r_sid  <= i_cfg_data[IV_W-1:0];
                    CFG_STEP_RATE:    r_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_MAX_RATIO:    r_msr  <= i_cfg_data[MSR_W-1:0];
                    default: ;
                endcase
            end

            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_target    <= i_target_interval;
                        r_goto      <= i_goto_mode;
                        r_dist      <= i_goto_distance;
                        r_div_dvd   <= DW'(r_sid);
                        r_div_dvs   <= DV'(n_msr_eff);
                        r_state     <= S_MINIV;
                    end
                end
                S_MINIV: begin
                    if (w_div_done) begin
                        r_div_dvd   <= DW'(r_sid);
                        r_div_dvs   <= DV'(n_iv);
                        r_ivs       <= IVS_W'(n_iv);
                        r_state     <= S_RATIO;
                    end
                end
                S_RATIO: begin
                    if (w_div_done) begin
                        r_stages <= f_stage_count(w_q[IV_W-1:0]);
                        r_ivs    <= r_ivs * IVS_W'(f_stage_count(w_q[IV_W-1:0]));
                        r_num    <= '0;
                        r_mcnt   <= MC_W'(IVS_W);
                        r_i      <= STG_W'(1);
                        r_den    <= DEN_W'(n_rate_eff);
                        r_cum    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num  <= n_num;
                    r_ivs  <= {r_ivs[IVS_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - MC_W'(1);
                    if (r_mcnt == MC_W'(1)) begin
                        r_state <= S_STAGE;
                    end
                end
                S_STAGE: begin
                    // count = round(num / den)
                    r_div_dvd   <= DW'({r_num, 1'b0}) + DW'(r_den);
                    r_div_dvs   <= {r_den, 1'b0};
                    r_state     <= S_CNT;
                end
                S_CNT: begin
                    if (w_div_done) begin
                        r_count     <= w_q[NUM_W-1:0];
                        r_div_dvd   <= w_q;
                        r_div_dvs   <= DV'(TIMER_LIMIT);
                        r_state     <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (w_div_done) begin
                        // period = round(count / j)
                        r_j         <= n_j;
                        r_div_dvd   <= DW'({r_count, 1'b0}) + DW'(n_j);
                        r_div_dvs   <= DV'({n_j, 1'b0});
                        r_state     <= S_PER;
                    end
                end
                S_PER: begin
                    if (w_div_done) begin
                        r_period <= n_period;
                        r_emit   <= 1'b1;
                    end
                    // Hold the stage until the output register frees up
                    if (n_load) begin
                        r_emit        <= 1'b0;
                        r_ramp_stage  <= STAGE_W'(r_i);
                        r_prescaler   <= PRE_W'(r_j - J_W'(1));
                        r_period_out  <= r_period;
                        r_compare     <= r_period[PER_W-1:1];
                        r_stage_steps <= (r_goto && n_final) ? n_steps_fin : DIST_W'(r_i);
                        r_decelerate  <= n_dec;
                        r_hold_speed  <= !r_goto && (r_i == r_stages);
                        r_last        <= n_final;
                        if (n_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cum   <= n_cum;
                            r_i     <= r_i + STG_W'(1);
                            r_den   <= r_den + DEN_W'(n_rate_eff);
                            r_state <= S_STAGE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ramp_stage  = r_ramp_stage;
    assign o_prescaler   = r_prescaler;
    assign o_period      = r_period_out;
    assign o_compare     = r_compare;
    assign o_stage_steps = r_stage_steps;
    assign o_decelerate  = r_decelerate;
    assign o_hold_speed  = r_hold_speed;
    assign o_last        = r_last;

endmodule

// File: hdl/srtt_chk.sv
// ----------------------------------------------------------------------------
// srtt_chk - port-level checks for the stepper ramp timer table
// Watches the result channel and the consistency of each ramp stage.
// ----------------------------------------------------------------------------
module srtt_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [srtt_pkg::STAGE_W-1:0] o_ramp_stage,
    input logic [srtt_pkg::PER_W-1:0]   o_period,
    input logic [srtt_pkg::CMP_W-1:0]   o_compare,
    input logic                         o_decelerate,
    input logic                         o_hold_speed,
    input logic                         o_last
);

    import srtt_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ramp_stage != '0) && (o_ramp_stage <= STAGES_30))
        else $error("ramp stage out of range");

    a_compare_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compare == o_period[PER_W-1:1]))
        else $error("compare is not half the period");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hold_speed |-> o_last && !o_decelerate)
        else $error("hold stage is not a plain last stage");

    a_dec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decelerate |-> o_last)
        else $error("decelerate on a stage that is not last");

endmodule

bind stepper_ramp_timer_table srtt_chk u_srtt_chk (.*);
